FILE: src/chi_pkg.sv
// shared types and constants for the cuckoo hash insert block
// used by the controller, datapath, top level and checker
`default_nettype none
package chi_pkg;
	typedef struct packed {
		logic [63:0] key;
		logic [31:0] payload;
	} in_item_t;

	typedef struct packed {
		logic        inserted;
		logic [63:0] dropped_key;
		logic [31:0] dropped_payload;
		logic [10:0] entry_count;
	} out_item_t;

	localparam logic [31:0] DJB2_INIT = 32'd5381;
	localparam logic [7:0]  RETRIES_RESET = 8'd100;

	// datapath operations
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_LOAD,
		OP_HASH,
		OP_READ1,
		OP_SWAP1,
		OP_READ2,
		OP_SWAP2
	} op_t;

	typedef struct packed {
		op_t  op;
		logic hash_start;
		logic fill1;
		logic fill2;
		logic fail;
	} cmd_t;

	typedef struct packed {
		logic hash_done;
		logic valid1;
		logic valid2;
		logic ready;
	} sts_t;
endpackage
`default_nettype wire

FILE: src/chi_ctrl.sv
// controller state machine for the cuckoo hash insert
// depends on chi_pkg; drives chi_dp through cmd_t / sts_t
`default_nettype none
module chi_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire logic            cfg_we,
	input  wire logic [7:0]      cfg_data,
	output chi_pkg::cmd_t        cmd,
	input  wire chi_pkg::sts_t   sts
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_H1, ST_R1, ST_W1, ST_H2, ST_R2, ST_W2, ST_DONE
	} state_t;

	state_t     state_q;
	logic [7:0] retries_q;
	logic [7:0] round_q;

	assign in_stall = (state_q != ST_IDLE) || out_valid || !sts.ready;

	always_comb begin
		cmd = '0;
		cmd.op = chi_pkg::OP_IDLE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && !out_valid && sts.ready) begin
					cmd.op = chi_pkg::OP_LOAD;
					cmd.fail = (retries_q == 8'd0);
				end
			end
			ST_H1, ST_H2: cmd.op = chi_pkg::OP_HASH;
			ST_R1: cmd.op = chi_pkg::OP_READ1;
			ST_W1: begin
				cmd.op = chi_pkg::OP_SWAP1;
				cmd.fill1 = !sts.valid1;
				cmd.hash_start = sts.valid1;
			end
			ST_R2: cmd.op = chi_pkg::OP_READ2;
			ST_W2: begin
				cmd.op = chi_pkg::OP_SWAP2;
				cmd.fill2 = !sts.valid2;
				cmd.hash_start = sts.valid2 && (round_q + 8'd1 < retries_q);
				cmd.fail = sts.valid2 && !(round_q + 8'd1 < retries_q);
			end
			ST_DONE: cmd.op = chi_pkg::OP_IDLE;
			default: cmd.op = chi_pkg::OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			retries_q <= chi_pkg::RETRIES_RESET;
			round_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) retries_q <= cfg_data;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !out_valid && sts.ready) begin
						round_q <= '0;
						if (retries_q == 8'd0) begin
							out_valid <= 1'b1;
						end else begin
							state_q <= ST_H1;
						end
					end
				end
				ST_H1: if (sts.hash_done) state_q <= ST_R1;
				ST_R1: state_q <= ST_W1;
				ST_W1: begin
					if (!sts.valid1) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_H2;
					end
				end
				ST_H2: if (sts.hash_done) state_q <= ST_R2;
				ST_R2: state_q <= ST_W2;
				ST_W2: begin
					if (!sts.valid2 || !(round_q + 8'd1 < retries_q)) begin
						state_q <= ST_DONE;
					end else begin
						round_q <= round_q + 8'd1;
						state_q <= ST_H1;
					end
				end
				ST_DONE: begin
					out_valid <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: src/chi_dp.sv
// datapath: hash unit, two tables with valid bits, current item and count
// depends on chi_pkg; commanded by chi_ctrl
`default_nettype none
module chi_dp #(
	parameter int TABLE_SLOTS = 512,
	parameter int KEY_BYTES   = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire chi_pkg::in_item_t in_item,
	input  wire chi_pkg::cmd_t    cmd,
	output chi_pkg::sts_t         sts,
	output chi_pkg::out_item_t    out_item
);
	localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int BW = $clog2(KEY_BYTES + 1);
	localparam logic [32:0] RECIP = 33'(((64'd1 << (32 + AW)) + 64'(TABLE_SLOTS) - 64'd1)
		/ 64'(TABLE_SLOTS));

	logic [63:0] t1_key [TABLE_SLOTS];
	logic [31:0] t1_pay [TABLE_SLOTS];
	logic [63:0] t2_key [TABLE_SLOTS];
	logic [31:0] t2_pay [TABLE_SLOTS];
	logic        v1_mem [TABLE_SLOTS];
	logic        v2_mem [TABLE_SLOTS];

	logic [63:0] cur_key_q, rd_key_q;
	logic [31:0] cur_pay_q, rd_pay_q;
	logic [31:0] h1_q, h2_q;
	logic [31:0] q1_q, q2_q;
	logic [BW-1:0] idx_q;
	logic          hbusy_q;
	logic [AW-1:0] s1_q, s2_q;
	logic          rv_q;
	logic          inserted_q;
	logic [10:0]   count_q;
	logic [AW-1:0] clr_q;
	logic          clr_busy_q;

	logic [7:0]  ch;
	logic        hend;
	logic [AW-1:0] slot_mod1, slot_mod2;

	always_comb begin
		ch = cur_key_q[63 - 8*idx_q[BW-1:0] -: 8];
		hend = (idx_q == BW'(KEY_BYTES)) || (ch == 8'd0);
	end

	// quotient by reciprocal multiply, exact for every 32-bit hash
	function automatic logic [31:0] quo(input logic [31:0] h);
		logic [64:0] p;
		p = {33'd0, h} * {32'd0, RECIP};
		return 32'(p >> (32 + AW));
	endfunction

	function automatic logic [AW-1:0] red(input logic [31:0] h, input logic [31:0] q);
		logic [31:0] r;
		r = h - q * 32'(TABLE_SLOTS);
		return r[AW-1:0];
	endfunction

	assign slot_mod1 = red(h1_q, q1_q);
	assign slot_mod2 = red(h2_q, q2_q);

	assign sts.hash_done = hbusy_q && hend;
	assign sts.valid1 = rv_q;
	assign sts.valid2 = rv_q;
	assign sts.ready = !clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hbusy_q    <= 1'b0;
			count_q    <= '0;
			inserted_q <= 1'b0;
			idx_q      <= '0;
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else begin
			if (clr_busy_q) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(TABLE_SLOTS - 1)) clr_busy_q <= 1'b0;
			end
			if (cmd.op == chi_pkg::OP_LOAD) begin
				hbusy_q    <= !cmd.fail;
				idx_q      <= '0;
				inserted_q <= 1'b0;
				h1_q       <= chi_pkg::DJB2_INIT;
				h2_q       <= '0;
			end
			if (cmd.op == chi_pkg::OP_HASH && hbusy_q) begin
				if (hend) begin
					hbusy_q <= 1'b0;
					q1_q    <= quo(h1_q);
					q2_q    <= quo(h2_q);
				end else begin
					h1_q  <= (h1_q << 5) + h1_q + 32'(ch);
					h2_q  <= 32'(ch) + (h2_q << 6) + (h2_q << 16) - h2_q;
					idx_q <= idx_q + BW'(1);
				end
			end
			if (cmd.op == chi_pkg::OP_READ1) begin
				s1_q <= slot_mod1;
			end
			if (cmd.op == chi_pkg::OP_READ2) begin
				s2_q <= slot_mod2;
			end
			if (cmd.op == chi_pkg::OP_SWAP1) begin
				if (cmd.fill1) begin
					count_q    <= count_q + 11'd1;
					inserted_q <= 1'b1;
				end
			end
			if (cmd.op == chi_pkg::OP_SWAP2) begin
				if (cmd.fill2) begin
					count_q    <= count_q + 11'd1;
					inserted_q <= 1'b1;
				end
			end
			if (cmd.hash_start) begin
				hbusy_q <= 1'b1;
				idx_q   <= '0;
				h1_q    <= chi_pkg::DJB2_INIT;
				h2_q    <= '0;
			end
		end
	end

	// valid marks: cleared one slot per cycle after reset
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			v1_mem[clr_q] <= 1'b0;
			v2_mem[clr_q] <= 1'b0;
		end else begin
			if (cmd.op == chi_pkg::OP_SWAP1) v1_mem[s1_q] <= 1'b1;
			if (cmd.op == chi_pkg::OP_SWAP2) v2_mem[s2_q] <= 1'b1;
		end
		if (cmd.op == chi_pkg::OP_READ1) rv_q <= v1_mem[slot_mod1];
		if (cmd.op == chi_pkg::OP_READ2) rv_q <= v2_mem[slot_mod2];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == chi_pkg::OP_LOAD) begin
			cur_key_q <= in_item.key;
			cur_pay_q <= in_item.payload;
		end
		if (cmd.op == chi_pkg::OP_READ1) begin
			rd_key_q <= t1_key[slot_mod1];
			rd_pay_q <= t1_pay[slot_mod1];
		end
		if (cmd.op == chi_pkg::OP_READ2) begin
			rd_key_q <= t2_key[slot_mod2];
			rd_pay_q <= t2_pay[slot_mod2];
		end
		if (cmd.op == chi_pkg::OP_SWAP1) begin
			t1_key[s1_q] <= cur_key_q;
			t1_pay[s1_q] <= cur_pay_q;
			if (!cmd.fill1) begin
				cur_key_q <= rd_key_q;
				cur_pay_q <= rd_pay_q;
			end
		end
		if (cmd.op == chi_pkg::OP_SWAP2) begin
			t2_key[s2_q] <= cur_key_q;
			t2_pay[s2_q] <= cur_pay_q;
			if (!cmd.fill2) begin
				cur_key_q <= rd_key_q;
				cur_pay_q <= rd_pay_q;
			end
		end
	end

	always_comb begin
		out_item.inserted        = inserted_q;
		out_item.dropped_key     = inserted_q ? 64'd0 : cur_key_q;
		out_item.dropped_payload = inserted_q ? 32'd0 : cur_pay_q;
		out_item.entry_count     = count_q;
	end
endmodule
`default_nettype wire

FILE: src/cuckoo_hash_insert.sv
// top level of the two-table cuckoo hash insert block
// depends on chi_pkg, chi_ctrl and chi_dp
//
// channel | direction | handshake          | payload
// in      | in        | in_valid/in_stall  | chi_pkg::in_item_t
// out     | out       | out_valid/out_stall| chi_pkg::out_item_t
// cfg     | in        | cfg_we             | cfg_data (retry limit)
//
// each half round hashes the key byte by byte, then reads the slot and swaps it in,
// paced by the byte-serial hash unit and the single read/write port per table;
// the result is raised from a done state after the last half round.
// with zero retries the result is raised in the cycle after the item is taken.
// a result stays registered until taken; no new item enters meanwhile.
// after reset a clearing pass over every slot empties the valid marks;
// the input stalls until it ends.
`default_nettype none
module cuckoo_hash_insert #(
	parameter int TABLE_SLOTS = 512,
	parameter int KEY_BYTES   = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire chi_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output chi_pkg::out_item_t      out_item,
	input  wire logic               cfg_we,
	input  wire logic [7:0]         cfg_data
);
	chi_pkg::cmd_t cmd;
	chi_pkg::sts_t sts;

	chi_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.cfg_we, .cfg_data, .cmd, .sts
	);

	chi_dp #(.TABLE_SLOTS(TABLE_SLOTS), .KEY_BYTES(KEY_BYTES)) u_dp (
		.clk, .arst_n, .in_item, .cmd, .sts, .out_item
	);
endmodule
`default_nettype wire

FILE: src/chi_check.sv
// port-level checker for cuckoo_hash_insert, bound to the top level
// depends on chi_pkg
`default_nettype none
module chi_check (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire chi_pkg::out_item_t out_item
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while result pending");
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.inserted |-> out_item.dropped_key == 64'd0)
		else $error("inserted result has dropped key");
	a_one_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item accepted during insert");
endmodule

bind cuckoo_hash_insert chi_check u_chi_check (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_item
);
`default_nettype wire

FILE: sim/cuckoo_hash_insert_chk.sv
// checker for the cuckoo hash insert block: watches the item channels and the
// retry register, predicts each insert result and compares it field by field
// depends on chi_pkg
`default_nettype none
module cuckoo_hash_insert_chk #(
	parameter int TABLE_SLOTS = 512,
	parameter int KEY_BYTES   = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire chi_pkg::in_item_t  in_item,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire chi_pkg::out_item_t out_item,
	input  wire logic               cfg_we,
	input  wire logic [7:0]         cfg_data,
	output int                      errors,
	output int                      waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [63:0] t1_key [TABLE_SLOTS];
	logic [31:0] t1_pay [TABLE_SLOTS];
	bit          t1_full [TABLE_SLOTS];
	logic [63:0] t2_key [TABLE_SLOTS];
	logic [31:0] t2_pay [TABLE_SLOTS];
	bit          t2_full [TABLE_SLOTS];
	logic [10:0] fill_count;
	logic [7:0]  retries;
	chi_pkg::out_item_t expected_results [$];

	function automatic int unsigned key_char(logic [63:0] k, int i);
		return int'(k[63 - 8 * i -: 8]);
	endfunction

	function automatic int unsigned djb2_slot(logic [63:0] k);
		logic [31:0] h;
		int unsigned c;
		h = chi_pkg::DJB2_INIT;
		for (int i = 0; i < KEY_BYTES && i < 8; i++) begin
			c = key_char(k, i);
			if (c == 0)
				break;
			h = (h << 5) + h + c;
		end
		return h % TABLE_SLOTS;
	endfunction

	function automatic int unsigned sdbm_slot(logic [63:0] k);
		logic [31:0] h;
		int unsigned c;
		h = '0;
		for (int i = 0; i < KEY_BYTES && i < 8; i++) begin
			c = key_char(k, i);
			if (c == 0)
				break;
			h = c + (h << 6) + (h << 16) - h;
		end
		return h % TABLE_SLOTS;
	endfunction

	function automatic chi_pkg::out_item_t predict_insert(chi_pkg::in_item_t it);
		chi_pkg::out_item_t r;
		logic [63:0] k, tk;
		logic [31:0] p, tp;
		int unsigned s;
		bit placed;
		k = it.key;
		p = it.payload;
		placed = 0;
		for (int round = 0; round < retries && !placed; round++) begin
			s = djb2_slot(k);
			if (!t1_full[s]) begin
				t1_full[s] = 1;
				t1_key[s] = k;
				t1_pay[s] = p;
				fill_count = fill_count + 1'b1;
				placed = 1;
				break;
			end
			tk = t1_key[s];
			tp = t1_pay[s];
			t1_key[s] = k;
			t1_pay[s] = p;
			k = tk;
			p = tp;
			s = sdbm_slot(k);
			if (!t2_full[s]) begin
				t2_full[s] = 1;
				t2_key[s] = k;
				t2_pay[s] = p;
				fill_count = fill_count + 1'b1;
				placed = 1;
				break;
			end
			tk = t2_key[s];
			tp = t2_pay[s];
			t2_key[s] = k;
			t2_pay[s] = p;
			k = tk;
			p = tp;
		end
		r.inserted = placed;
		r.dropped_key = placed ? 64'd0 : k;
		r.dropped_payload = placed ? 32'd0 : p;
		r.entry_count = fill_count;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		chi_pkg::out_item_t exp_r;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				t1_full[i] = 0;
				t2_full[i] = 0;
			end
			fill_count = '0;
			retries = chi_pkg::RETRIES_RESET;
			expected_results.delete();
			errors <= 0;
			waiting <= 0;
		end else begin
			if (cfg_we)
				retries = cfg_data;
			if (in_valid && !in_stall)
				expected_results.push_back(predict_insert(in_item));
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$display("%t: unexpected result %p", $realtime, out_item);
					errors <= errors + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (out_item.inserted !== exp_r.inserted ||
					    out_item.dropped_key !== exp_r.dropped_key ||
					    out_item.dropped_payload !== exp_r.dropped_payload ||
					    out_item.entry_count !== exp_r.entry_count) begin
						$display("%t: inserted exp %0d got %0d", $realtime,
							exp_r.inserted, out_item.inserted);
						$display("%t: dropped_key exp %h got %h", $realtime,
							exp_r.dropped_key, out_item.dropped_key);
						$display("%t: dropped_payload exp %h got %h", $realtime,
							exp_r.dropped_payload, out_item.dropped_payload);
						$display("%t: entry_count exp %0d got %0d", $realtime,
							exp_r.entry_count, out_item.entry_count);
						errors <= errors + 1;
					end
				end
			end
			waiting <= expected_results.size();
		end
	end
endmodule
`default_nettype wire

FILE: sim/cuckoo_hash_insert_tb.sv
// top of the cuckoo hash insert testbench: clock, reset, stimulus and verdict
// depends on chi_pkg, cuckoo_hash_insert and cuckoo_hash_insert_chk
`default_nettype none
module cuckoo_hash_insert_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 1950;
	localparam int IDLE_LIMIT  = 60000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	chi_pkg::in_item_t  in_item;
	logic      out_valid;
	logic      out_stall;
	chi_pkg::out_item_t out_item;
	logic      cfg_we;
	logic [7:0] cfg_data;
	int        errors;
	int        waiting;
	int        sent;
	int        burst_left;
	int        stall_left;
	int        stall_mode;
	int        idle_cycles;

	cuckoo_hash_insert dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	cuckoo_hash_insert_chk chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.errors(errors), .waiting(waiting)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// short strings from a tiny alphabet collide often; the tail after the
	// terminator still makes the stored key differ
	function automatic logic [63:0] make_key(int len, bit narrow);
		logic [63:0] k;
		k = {$urandom, $urandom};
		for (int i = 0; i < len; i++)
			k[63 - 8 * i -: 8] = narrow ? 8'($urandom_range(97, 100))
				: 8'($urandom_range(1, 255));
		if (len < 8)
			k[63 - 8 * len -: 8] = 8'd0;
		return k;
	endfunction

	task automatic send_insert(logic [63:0] k, logic [31:0] p);
		@(negedge clk);
		in_valid = 1;
		in_item.key = k;
		in_item.payload = p;
		do @(posedge clk); while (in_stall);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			in_valid = 0;
			repeat ($urandom_range(0, 12)) @(negedge clk);
			burst_left = $urandom_range(0, 20);
		end
	endtask

	task automatic send_random;
		int len;
		len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 8);
		send_insert(make_key(len, 1'($urandom_range(0, 1))), $urandom);
	endtask

	task automatic set_retries(logic [7:0] v);
		@(negedge clk);
		in_valid = 0;
		while (waiting != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we = 1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 0;
	endtask

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 300);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= 1'($urandom_range(0, 1));
			2: out_stall <= $urandom_range(0, 9) < 8;
			default: out_stall <= $urandom_range(0, 9) < 2;
		endcase
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("cuckoo_hash_insert test failed");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_item = '0;
		out_stall = 0;
		cfg_we = 0;
		cfg_data = '0;
		sent = 0;
		burst_left = 0;
		stall_left = 0;
		stall_mode = 0;
		idle_cycles = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: field extremes, empty key, duplicates, embedded zero
		send_insert(64'd0, 32'd0);
		send_insert(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_insert(64'h00FF_FFFF_FFFF_FFFF, 32'h8000_0001);
		send_insert(64'h6100_0000_0000_0000, 32'h1);
		send_insert(64'h6100_0000_0000_0000, 32'h2);
		send_insert(64'h6100_0000_0000_0000, 32'h3);
		send_insert(64'h6100_FFFF_FFFF_FFFF, 32'h4);
		send_insert(64'h0102_0304_0506_0708, 32'h5555_AAAA);
		send_insert(64'h8080_8080_8080_8080, 32'hAAAA_5555);
		for (int i = 0; i < 8; i++)
			send_insert(make_key(1, 1), $urandom);
		set_retries(8'd0);
		send_insert(64'h6200_0000_0000_0000, 32'h7);
		send_insert(64'd0, 32'hFFFF_FFFF);
		set_retries(8'd1);
		for (int i = 0; i < 6; i++)
			send_insert(make_key(1, 1), $urandom);

		for (int i = 0; i < 150; i++)
			send_random();
		set_retries(8'd255);
		for (int i = 0; i < 25; i++)
			send_random();
		while (sent < ITEM_TARGET) begin
			set_retries(($urandom_range(0, 9) == 0) ? 8'd100 : 8'($urandom_range(1, 16)));
			repeat ($urandom_range(100, 250))
				if (sent < ITEM_TARGET)
					send_random();
		end

		@(negedge clk);
		in_valid = 0;
		while (waiting != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (errors == 0)
			$display("cuckoo_hash_insert test passed");
		else
			$display("cuckoo_hash_insert test failed");
		$finish;
	end
endmodule
`default_nettype wire
